### design/ipc_pkg.sv
package ipc_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int DIM_W      = 7;
  localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(MAX_HEIGHT);

  typedef logic [MAX_WIDTH-1:0] line_t;

  typedef struct packed {
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;
  } ipc_dims_t;

  typedef struct packed {
    logic done;
    logic ok;
  } ipc_result_t;

endpackage

### design/ipc_if.sv
interface ipc_pixel_if;
  logic valid;
  logic ready;
  logic pixel_set;

  modport source (output valid, output pixel_set, input ready);
  modport sink (input valid, input pixel_set, output ready);
endinterface

interface ipc_result_if;
  logic valid;
  logic ready;
  logic image_ok;

  modport source (output valid, output image_ok, input ready);
  modport sink (input valid, input image_ok, output ready);
endinterface

### design/isolated_pixel_check.sv
// Streaming 4-neighbor isolated pixel check. Pixels of a binary image enter in raster order,
// one item per clock, image_width per row and image_height rows (a zero acts as one, values
// above 64 act as 64). Each item is taken into an input register and then settled against the
// 64-bit line registers above_r, cur_r and pend_r, so the block sustains one pixel per cycle;
// each image's result goes into a result register, and only a full result register
// that is not being taken holds the input back. After the last pixel of an image one item
// carries image_ok, which is 0 when some set pixel has no set neighbor above, below, left or
// right, and the block starts a fresh image. Width and height may be written between images
// or between pixels and take effect on the next pixel; no clearing pass is needed after reset.
module isolated_pixel_check (
  input  logic                           clk,
  input  logic                           rst_n,
  ipc_pixel_if.sink                      in_ch,
  ipc_result_if.source                   out_ch,
  input  logic                           cfg_we,
  input  logic [ipc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ipc_pkg::*;

  ipc_dims_t   dims;
  ipc_result_t res;

  logic in_valid_r, in_valid_nxt;
  logic pix_r;
  logic out_valid_r, out_valid_nxt;
  logic ok_r;
  logic advance;

  ipc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dims      (dims)
  );

  ipc_row_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .pixel (pix_r),
    .dims  (dims),
    .res   (res)
  );

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.image_ok = ok_r;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ch.ready) begin
      in_valid_nxt = in_ch.valid;
    end
    out_valid_nxt = out_valid_r;
    if (res.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      pix_r <= in_ch.pixel_set;
    end
    if (res.done) begin
      ok_r <= res.ok;
    end
  end

endmodule

### design/ipc_cfg_regs.sv
module ipc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ipc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipc_pkg::CFG_DATA_W-1:0] cfg_data,
  output ipc_pkg::ipc_dims_t           dims
);
  import ipc_pkg::*;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero acts as one and anything above the maximum acts as the maximum.
  always_comb begin
    logic [DIM_W-1:0] w_m1;
    logic [DIM_W-1:0] h_m1;
    w_m1 = width_r - 1'b1;
    h_m1 = height_r - 1'b1;
    if (width_r == '0) begin
      dims.col_last = '0;
    end else if (width_r > DIM_W'(MAX_WIDTH)) begin
      dims.col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      dims.col_last = w_m1[COL_W-1:0];
    end
    if (height_r == '0) begin
      dims.row_last = '0;
    end else if (height_r > DIM_W'(MAX_HEIGHT)) begin
      dims.row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      dims.row_last = h_m1[ROW_W-1:0];
    end
  end

endmodule

### design/ipc_row_engine.sv
module ipc_row_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 pixel,
  input  ipc_pkg::ipc_dims_t   dims,
  output ipc_pkg::ipc_result_t res
);
  import ipc_pkg::*;

  line_t            above_r, above_nxt;
  line_t            cur_r, cur_nxt;
  line_t            pend_r, pend_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             seen_r, seen_nxt;

  logic [COL_W-1:0] col_eff;
  logic             row_end;
  logic             last_row;
  line_t            mask;
  line_t            line;
  line_t            up;
  line_t            pend;
  logic             hit;
  logic             pend_any;

  always_comb begin
    col_eff  = (col_r >= dims.col_last) ? dims.col_last : col_r;
    row_end  = (col_eff == dims.col_last);
    last_row = (row_r >= dims.row_last);
    for (int c = 0; c < MAX_WIDTH; c++) begin
      mask[c] = (COL_W'(c) <= dims.col_last);
    end
    line          = cur_r;
    line[col_eff] = pixel;
    up            = (row_r != '0) ? above_r : '0;
    // A set pixel with no set neighbor to the left, right or above still waits on the row below.
    pend     = line & ~(line << 1) & ~((line & mask) >> 1) & ~up & mask;
    pend_any = |pend;
    hit      = (row_r != '0) && (|(pend_r & ~line & mask));
  end

  always_comb begin
    above_nxt = above_r;
    cur_nxt   = cur_r;
    pend_nxt  = pend_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    seen_nxt  = seen_r;
    res.done  = 1'b0;
    res.ok    = !(seen_r || hit || pend_any);
    if (step) begin
      if (!row_end) begin
        cur_nxt = line;
        col_nxt = col_eff + 1'b1;
      end else if (!last_row) begin
        above_nxt = line;
        cur_nxt   = '0;
        pend_nxt  = (pend_r & ~mask) | pend;
        col_nxt   = '0;
        row_nxt   = row_r + 1'b1;
        seen_nxt  = seen_r || hit;
      end else begin
        res.done  = 1'b1;
        above_nxt = '0;
        cur_nxt   = '0;
        pend_nxt  = '0;
        col_nxt   = '0;
        row_nxt   = '0;
        seen_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r <= '0;
      cur_r   <= '0;
      pend_r  <= '0;
      col_r   <= '0;
      row_r   <= '0;
      seen_r  <= 1'b0;
    end else begin
      above_r <= above_nxt;
      cur_r   <= cur_nxt;
      pend_r  <= pend_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule
